### rtl/argb8888_premultiplied_blend_assert.svh
// Assertion macros shared by the blend RTL.
`ifndef ARGB8888_PREMULTIPLIED_BLEND_ASSERT_SVH
`define ARGB8888_PREMULTIPLIED_BLEND_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define APB_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("blend pipeline: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define APB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("blend pipeline: next-cycle check failed");

`endif

### rtl/apb_pkg.sv
package apb_pkg;

    // Alpha thresholds: at or above HI counts as opaque, at or below LO as clear.
    localparam logic [7:0] OPA_HI = 8'd253;
    localparam logic [7:0] OPA_LO = 8'd2;
    localparam logic [7:0] OPA_FULL = 8'd255;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SOURCE_KIND = 2'd0;
    localparam logic [1:0] CFG_FILL_COLOR  = 2'd1;
    localparam logic [1:0] CFG_OPACITY     = 2'd2;
    localparam logic [1:0] CFG_MASK_ENABLE = 2'd3;

    localparam int unsigned CFG_DATA_W = 24;

    // Color channels: index 2 red, 1 green, 0 blue.
    typedef logic [2:0][7:0] t_rgb;

    // One lane of the restoring divider.
    typedef struct packed {
        logic [7:0] rem;
        logic [7:0] low;
        logic [7:0] quo;
        logic       sat;
    } t_div_lane;

    typedef struct packed {
        t_div_lane [2:0] lane;
        logic [7:0]      den;
    } t_div_stage;

    // Saturate a 9-bit sum to one byte.
    function automatic logic [7:0] sat8(logic [8:0] v);
        return v[8] ? 8'hFF : v[7:0];
    endfunction

    // One quotient bit of restoring division.
    function automatic t_div_lane div_step(t_div_lane l, logic [7:0] den);
        logic [8:0] t;
        logic [8:0] d;
        t_div_lane  o;
        t = {l.rem, l.low[7]};
        d = {1'b0, den};
        o = l;
        o.low = {l.low[6:0], 1'b0};
        if (t >= d) begin
            o.rem = 8'(t - d);
            o.quo = {l.quo[6:0], 1'b1};
        end else begin
            o.rem = t[7:0];
            o.quo = {l.quo[6:0], 1'b0};
        end
        return o;
    endfunction

endpackage

### rtl/apb_div_pipe.sv
module apb_div_pipe (
    input  logic              i_clk,
    input  logic [4:0]        i_en,     // stage load enables, bit 0 is the first stage
    input  apb_pkg::t_rgb     i_color,
    input  logic [7:0]        i_alpha,
    output apb_pkg::t_rgb     o_quot
);

    // Five stages: setup of color*255 and the overflow test, then two bits a stage.
    apb_pkg::t_div_stage r_st [1:5];
    apb_pkg::t_div_stage n_st [1:5];

    always_comb begin
        logic [15:0] num;
        n_st[1].den = i_alpha;
        for (int c = 0; c < 3; c++) begin
            num = {i_color[c], 8'h00} - {8'h00, i_color[c]};
            n_st[1].lane[c].sat = (num >= {i_alpha, 8'h00});
            n_st[1].lane[c].rem = num[15:8];
            n_st[1].lane[c].low = num[7:0];
            n_st[1].lane[c].quo = 8'h00;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_st[1] <= n_st[1];
        end
    end

    for (genvar k = 2; k <= 5; k++) begin : g_step
        always_comb begin
            n_st[k].den = r_st[k-1].den;
            for (int c = 0; c < 3; c++) begin
                n_st[k].lane[c] = apb_pkg::div_step(
                    apb_pkg::div_step(r_st[k-1].lane[c], r_st[k-1].den), r_st[k-1].den);
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en[k-1]) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            o_quot[c] = r_st[5].lane[c].sat ? 8'hFF : r_st[5].lane[c].quo;
        end
    end

endmodule

### rtl/argb8888_premultiplied_blend.sv
// Channel   Dir  Handshake                      Contents (low bit up)
// s_axis    in   s_axis_tvalid/s_axis_tready    dest_pixel, src_pixel, mask_value
// m_axis    out  m_axis_tvalid/m_axis_tready    result_pixel
// cfg       in   i_cfg_we (no wait)             i_cfg_addr selects, i_cfg_wdata value
//
// One pixel per clock sustained while the output is ready; an input transfer reaches
// output valid through the image-mode divider (five stages) plus two stages of blend math.
// Reset clears the stage valid bits and loads the register defaults (opacity 255).
// Each stage has its own ready, so bubbles collapse and a stalled output only blocks
// once every stage holds a pixel; nothing is dropped or repeated.
`include "argb8888_premultiplied_blend_assert.svh"

module argb8888_premultiplied_blend (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [apb_pkg::CFG_DATA_W-1:0] i_cfg_wdata,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // [31:0] dest_pixel, [63:32] src_pixel,
                                        // [71:64] mask_value

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // [31:0] result_pixel
);

    typedef enum logic [1:0] {
        SEL_FG,     // foreground wins outright
        SEL_BG,     // foreground too clear, keep destination
        SEL_OPQ,    // opaque destination, additive blend
        SEL_BLEND   // general blend
    } t_mix_sel;

    // Side data that rides alongside the divider.
    typedef struct packed {
        logic [7:0]    fa;
        apb_pkg::t_rgb fc;
        logic [31:0]   dst;
        logic          keep;
    } t_pipe;

    typedef struct packed {
        t_mix_sel      sel;
        logic [7:0]    fa;
        apb_pkg::t_rgb fc;
        apb_pkg::t_rgb fgt;
        apb_pkg::t_rgb bgt;
        logic [7:0]    amul;
        logic [31:0]   dst;
    } t_mix;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic        r_kind;
    logic [23:0] r_color;
    logic [7:0]  r_opa;
    logic        r_mask_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind    <= 1'b0;
            r_color   <= 24'h000000;
            r_opa     <= apb_pkg::OPA_FULL;
            r_mask_en <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                apb_pkg::CFG_SOURCE_KIND: r_kind    <= i_cfg_wdata[0];
                apb_pkg::CFG_FILL_COLOR:  r_color   <= i_cfg_wdata[23:0];
                apb_pkg::CFG_OPACITY:     r_opa     <= i_cfg_wdata[7:0];
                apb_pkg::CFG_MASK_ENABLE: r_mask_en <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage valids and per-stage load enables
    // ------------------------------------------------------------------
    logic [7:1] r_v;
    logic [8:1] w_en;

    // A stage loads when it is empty or its successor is loading too.
    always_comb begin
        w_en[8] = m_axis_tready;
        for (int k = 7; k >= 1; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    assign s_axis_tready = w_en[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[1]) begin
                r_v[1] <= s_axis_tvalid;
            end
            for (int k = 2; k <= 7; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: foreground alpha, fill premultiply by opacity
    // ------------------------------------------------------------------
    logic [31:0]   w_dst;
    logic [31:0]   w_src;
    logic [7:0]    w_mask;
    apb_pkg::t_rgb w_src_rgb;
    t_pipe         n_p1;

    assign w_dst     = s_axis_tdata[31:0];
    assign w_src     = s_axis_tdata[63:32];
    assign w_mask    = s_axis_tdata[71:64];
    assign w_src_rgb = w_src[23:0];

    always_comb begin
        logic        opa_hi;
        logic [7:0]  op;
        logic [15:0] img_prod;
        logic [15:0] msk_prod;
        logic [15:0] col_prod;
        logic [7:0]  mask_alpha;
        logic        opaque_fill;

        col_prod    = '0;
        opa_hi      = (r_opa >= apb_pkg::OPA_HI);
        opaque_fill = !r_mask_en && opa_hi;
        op          = r_mask_en ? w_mask : r_opa;
        img_prod    = w_src[31:24] * op;
        msk_prod    = w_mask * r_opa;
        mask_alpha  = opa_hi ? w_mask : msk_prod[15:8];

        n_p1.dst  = w_dst;
        n_p1.keep = (w_src[31:24] == 8'h00);
        if (r_kind) begin
            // Scale source alpha by mask, or by opacity when it is not near full.
            n_p1.fa = (r_mask_en || !opa_hi) ? img_prod[15:8] : w_src[31:24];
            n_p1.fc = w_src_rgb;
        end else begin
            if (r_mask_en) begin
                n_p1.fa = mask_alpha;
            end else begin
                n_p1.fa = opa_hi ? apb_pkg::OPA_FULL : r_opa;
            end
            // Opaque fill takes the color as is; mixing then passes it through.
            for (int c = 0; c < 3; c++) begin
                col_prod   = r_color[c*8 +: 8] * r_opa;
                n_p1.fc[c] = opaque_fill ? r_color[c*8 +: 8] : col_prod[15:8];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stages 2..5: second fill premultiply (masked fill), divider runs alongside
    // ------------------------------------------------------------------
    t_pipe r_p [1:5];
    t_pipe n_p2;

    always_comb begin
        logic [15:0] prod;
        prod = '0;
        n_p2 = r_p[1];
        if (!r_kind && r_mask_en) begin
            for (int c = 0; c < 3; c++) begin
                prod       = r_p[1].fc[c] * r_p[1].fa;
                n_p2.fc[c] = prod[15:8];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_p[1] <= n_p1;
        end
        if (w_en[2]) begin
            r_p[2] <= n_p2;
        end
        for (int k = 3; k <= 5; k++) begin
            if (w_en[k]) begin
                r_p[k] <= r_p[k-1];
            end
        end
    end

    apb_pkg::t_rgb w_quot;

    apb_div_pipe u_div (
        .i_clk   (i_clk),
        .i_en    (w_en[5:1]),
        .i_color (w_src_rgb),
        .i_alpha (w_src[31:24]),
        .o_quot  (w_quot)
    );

    // ------------------------------------------------------------------
    // Stage 6: mix case and products
    // ------------------------------------------------------------------
    t_mix r_m6;
    t_mix n_m6;

    always_comb begin
        apb_pkg::t_rgb fc;
        logic [7:0]    fa;
        logic [7:0]    ba;
        logic          b_full;
        logic [7:0]    inv;
        logic [7:0]    aop;
        logic [15:0]   bprod;
        logic [15:0]   fprod;
        logic [15:0]   aprod;

        // Un-premultiplied color in image mode, except a clear source keeps its own.
        fc     = (r_kind && !r_p[5].keep) ? w_quot : r_p[5].fc;
        fa     = r_p[5].fa;
        ba     = r_p[5].dst[31:24];
        b_full = (ba == apb_pkg::OPA_FULL);
        inv    = b_full ? 8'(apb_pkg::OPA_HI - fa) : 8'(apb_pkg::OPA_FULL - fa);
        aop    = b_full ? ba : 8'(apb_pkg::OPA_FULL - ba);
        aprod  = inv * aop;

        if (fa >= apb_pkg::OPA_HI || ba <= apb_pkg::OPA_LO) begin
            n_m6.sel = SEL_FG;
        end else if (fa <= apb_pkg::OPA_LO) begin
            n_m6.sel = SEL_BG;
        end else if (b_full) begin
            n_m6.sel = SEL_OPQ;
        end else begin
            n_m6.sel = SEL_BLEND;
        end

        for (int c = 0; c < 3; c++) begin
            bprod       = r_p[5].dst[c*8 +: 8] * inv;
            fprod       = fc[c] * fa;
            n_m6.bgt[c] = bprod[15:8];
            n_m6.fgt[c] = b_full ? fc[c] : fprod[15:8];
        end

        n_m6.fa   = fa;
        n_m6.fc   = fc;
        n_m6.amul = aprod[15:8];
        n_m6.dst  = r_p[5].dst;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[6]) begin
            r_m6 <= n_m6;
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: saturating sums and final select into the output register
    // ------------------------------------------------------------------
    logic [31:0] r_out;
    logic [31:0] n_out;

    always_comb begin
        apb_pkg::t_rgb sum;
        for (int c = 0; c < 3; c++) begin
            sum[c] = apb_pkg::sat8({1'b0, r_m6.fgt[c]} + {1'b0, r_m6.bgt[c]});
        end
        case (r_m6.sel)
            SEL_FG:  n_out = {r_m6.fa, r_m6.fc};
            SEL_BG:  n_out = r_m6.dst;
            SEL_OPQ: n_out = {apb_pkg::sat8({1'b0, r_m6.fa} + {1'b0, r_m6.amul}), sum};
            default: n_out = {8'(apb_pkg::OPA_FULL - r_m6.amul), sum};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en[7]) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_v[7];
    assign m_axis_tdata  = r_out;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Input back-pressure only when every stage is occupied and the output is blocked.
    `APB_ASSERT_IMPLY(a_full_stall_blocks, i_clk, i_rst_n, (&r_v) && !m_axis_tready, !s_axis_tready)
    // An empty first stage always takes a transfer.
    `APB_ASSERT_IMPLY(a_empty_accepts, i_clk, i_rst_n, !r_v[1], s_axis_tready)
    // A held pixel in front of a blocked stage is not lost.
    `APB_ASSERT_NEXT(a_hold_stage6, i_clk, i_rst_n, r_v[6] && !w_en[7], r_v[6])

endmodule

### dv/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import apb_pkg::*;

    // Stage count of the pipeline; sizes the drain waits.
    localparam int unsigned PIPE_LATENCY = 7;
    // Output hold-off used to back the pipeline up into the input.
    localparam int unsigned LONG_HOLD    = 150;
    localparam int unsigned CYCLE_LIMIT  = 300000;
    localparam int unsigned PHASES       = 8;
    localparam int unsigned PHASE_ITEMS  = 50;
    localparam int unsigned REPORT_MAX   = 10;

    // Clock, reset and every block input start at known values.
    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic [1:0]  i_cfg_addr    = CFG_SOURCE_KIND;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata  = '0;   // [31:0] dest_pixel, [63:32] src_pixel,
                                       // [71:64] mask_value
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;         // [31:0] result_pixel

    argb8888_premultiplied_blend dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // Shadow of the block's registers, as seen by the pixel predictor.
    logic        cfg_kind    = 1'b0;
    logic [23:0] cfg_color   = 24'h000000;
    logic [7:0]  cfg_opacity = 8'd255;
    logic        cfg_mask_en = 1'b0;

    // Result pixels predicted for transfers already accepted, oldest first.
    logic [31:0] pending_pixels[$];

    int unsigned pixels_sent    = 0;
    int unsigned pixels_checked = 0;
    int unsigned mismatches     = 0;
    int unsigned settings_used  = 1;
    int unsigned cycle_count    = 0;
    int unsigned src_calm       = 0;
    int unsigned sink_calm      = 0;
    bit          hold_request   = 1'b0;

    typedef struct {
        int unsigned a;
        int unsigned r;
        int unsigned g;
        int unsigned b;
    } t_chan;

    // One directed stimulus row: register setting, input fields, and the
    // result when it can be typed in directly.
    typedef struct packed {
        logic        kind;
        logic [23:0] color;
        logic [7:0]  opa;
        logic        men;
        logic [31:0] dest;
        logic [31:0] src;
        logic [7:0]  mask;
        logic        typed;
        logic [31:0] want;
    } t_row;

    localparam int unsigned ROW_COUNT = 23;
    localparam t_row DIRECTED_ROWS [ROW_COUNT] = '{
        // reset setting: opaque black fill
        '{1'b0, 24'h000000, 8'd255, 1'b0, 32'h12345678, 32'hDEADBEEF, 8'h5A, 1'b1, 32'hFF000000},
        '{1'b0, 24'hFFFFFF, 8'd255, 1'b0, 32'h00000000, 32'h00000000, 8'h00, 1'b1, 32'hFFFFFFFF},
        '{1'b0, 24'h0A1B2C, 8'd253, 1'b0, 32'h80808080, 32'hFFFFFFFF, 8'hFF, 1'b1, 32'hFF0A1B2C},
        '{1'b0, 24'hFFFFFF, 8'd252, 1'b0, 32'hFFFFFFFF, 32'h00000000, 8'h00, 1'b0, 32'h0},
        '{1'b0, 24'hFFFFFF, 8'd3,   1'b0, 32'hFFFFFFFF, 32'h00000000, 8'h00, 1'b0, 32'h0},
        // opacity at the clear threshold leaves the destination alone
        '{1'b0, 24'hFFFFFF, 8'd2,   1'b0, 32'h7F102030, 32'h00000000, 8'h00, 1'b1, 32'h7F102030},
        '{1'b0, 24'hC08040, 8'd128, 1'b0, 32'h80808080, 32'h00000000, 8'h00, 1'b0, 32'h0},
        '{1'b0, 24'hFFFFFF, 8'd0,   1'b0, 32'h01FFFFFF, 32'h00000000, 8'h00, 1'b0, 32'h0},
        // masked fill: zero coverage keeps the destination
        '{1'b0, 24'hFFFFFF, 8'd255, 1'b1, 32'hFF112233, 32'h00000000, 8'h00, 1'b1, 32'hFF112233},
        '{1'b0, 24'hFFFFFF, 8'd255, 1'b1, 32'h00000000, 32'h00000000, 8'hFF, 1'b0, 32'h0},
        '{1'b0, 24'h804020, 8'd100, 1'b1, 32'hFFFFFFFF, 32'h00000000, 8'hC8, 1'b0, 32'h0},
        '{1'b0, 24'hFFFFFF, 8'd0,   1'b1, 32'h40FFFFFF, 32'h00000000, 8'hFF, 1'b1, 32'h40FFFFFF},
        // image mode: opaque source copies through, clear source keeps the destination
        '{1'b1, 24'h000000, 8'd255, 1'b0, 32'h12345678, 32'hFF336699, 8'h00, 1'b1, 32'hFF336699},
        '{1'b1, 24'h000000, 8'd255, 1'b0, 32'h80010203, 32'h00AABBCC, 8'h00, 1'b1, 32'h80010203},
        // clear source over a clear destination keeps its color channels
        '{1'b1, 24'h000000, 8'd255, 1'b0, 32'h00000000, 32'h00AABBCC, 8'h00, 1'b1, 32'h00AABBCC},
        // un-premultiply overflow saturates
        '{1'b1, 24'h000000, 8'd255, 1'b0, 32'hFFFFFFFF, 32'h10FFFFFF, 8'h00, 1'b0, 32'h0},
        '{1'b1, 24'h000000, 8'd255, 1'b0, 32'h40FF00FF, 32'h80402010, 8'h00, 1'b0, 32'h0},
        '{1'b1, 24'h000000, 8'd128, 1'b0, 32'hFF000000, 32'hC0C0C0C0, 8'h00, 1'b0, 32'h0},
        '{1'b1, 24'h000000, 8'd0,   1'b0, 32'hFF123456, 32'hFFFFFFFF, 8'h00, 1'b1, 32'hFF123456},
        // mask on: opacity no longer counts
        '{1'b1, 24'h000000, 8'd0,   1'b1, 32'hFFFFFFFF, 32'hFF808080, 8'h80, 1'b0, 32'h0},
        '{1'b1, 24'h000000, 8'd255, 1'b1, 32'h00000000, 32'hFFFFFFFF, 8'hFF, 1'b0, 32'h0},
        '{1'b1, 24'h000000, 8'd255, 1'b1, 32'hFF00FF00, 32'hFFFFFFFF, 8'h00, 1'b1, 32'hFF00FF00},
        '{1'b0, 24'h000000, 8'd255, 1'b0, 32'hFFFFFFFF, 32'h00000000, 8'h00, 1'b1, 32'hFF000000}
    };

    function automatic int unsigned sat_byte(int unsigned v);
        return (v > 255) ? 255 : v;
    endfunction

    function automatic t_chan split_argb(logic [31:0] v);
        t_chan p;
        p.a = v[31:24];
        p.r = v[23:16];
        p.g = v[15:8];
        p.b = v[7:0];
        return p;
    endfunction

    function automatic t_chan premultiply(t_chan p);
        t_chan o;
        o = p;
        o.r = (p.r * p.a) >> 8;
        o.g = (p.g * p.a) >> 8;
        o.b = (p.b * p.a) >> 8;
        return o;
    endfunction

    // Predict the blended pixel under the current register shadow.
    function automatic logic [31:0] blend_pixel(logic [31:0] dest, logic [31:0] src,
                                                logic [7:0] mask);
        t_chan       fg;
        t_chan       bg;
        t_chan       blended;
        int unsigned inv;
        int unsigned m;
        int unsigned opa;
        m   = mask;
        opa = cfg_opacity;
        bg  = split_argb(dest);
        if (!cfg_kind) begin
            // Opaque fill without a mask is a plain copy of the color.
            if (!cfg_mask_en && opa >= OPA_HI)
                return {8'hFF, cfg_color};
            fg   = split_argb({8'h00, cfg_color});
            fg.a = opa;
            fg   = premultiply(fg);
            if (cfg_mask_en) begin
                fg.a = (opa >= OPA_HI) ? m : ((m * opa) >> 8);
                fg   = premultiply(fg);
            end
        end else begin
            fg = split_argb(src);
            // Undo the premultiply; a clear pixel keeps its channels.
            if (fg.a > 0) begin
                fg.r = sat_byte((fg.r * 255) / fg.a);
                fg.g = sat_byte((fg.g * 255) / fg.a);
                fg.b = sat_byte((fg.b * 255) / fg.a);
            end
            if (cfg_mask_en)
                fg.a = (fg.a * m) >> 8;
            else if (opa < OPA_HI)
                fg.a = (fg.a * opa) >> 8;
        end
        // Mix the foreground over the destination.
        if (fg.a >= OPA_HI || bg.a <= OPA_LO) begin
            blended = fg;
        end else if (fg.a <= OPA_LO) begin
            blended = bg;
        end else if (bg.a == OPA_FULL) begin
            inv       = OPA_HI - fg.a;
            blended.r = sat_byte(fg.r + ((bg.r * inv) >> 8));
            blended.g = sat_byte(fg.g + ((bg.g * inv) >> 8));
            blended.b = sat_byte(fg.b + ((bg.b * inv) >> 8));
            blended.a = sat_byte(fg.a + ((bg.a * inv) >> 8));
        end else begin
            inv       = OPA_FULL - fg.a;
            blended.a = OPA_FULL - ((inv * (OPA_FULL - bg.a)) >> 8);
            fg        = premultiply(fg);
            blended.r = sat_byte(fg.r + ((bg.r * inv) >> 8));
            blended.g = sat_byte(fg.g + ((bg.g * inv) >> 8));
            blended.b = sat_byte(fg.b + ((bg.b * inv) >> 8));
        end
        return {8'(blended.a), 8'(blended.r), 8'(blended.g), 8'(blended.b)};
    endfunction

    // Idle length for either side: mostly none or short, now and then long,
    // with occasional calm stretches that have no idling at all.
    function automatic int unsigned pick_gap(inout int unsigned calm);
        int unsigned r;
        if (calm != 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2)
            calm = $urandom_range(30, 100);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Random ARGB word; most are well-formed premultiplied (no channel
    // above alpha), alpha leans on the thresholds.
    function automatic logic [31:0] rand_argb();
        logic [7:0]  a;
        logic [31:0] v;
        case ($urandom_range(0, 5))
            0:       a = 8'd255;
            1:       a = 8'($urandom_range(0, 2));
            2:       a = 8'($urandom_range(253, 254));
            3:       a = 8'd0;
            default: a = 8'($urandom_range(0, 255));
        endcase
        v = $urandom;
        if ($urandom_range(0, 9) < 6) begin
            v[23:16] = 8'($urandom_range(0, a));
            v[15:8]  = 8'($urandom_range(0, a));
            v[7:0]   = 8'($urandom_range(0, a));
        end
        v[31:24] = a;
        return v;
    endfunction

    function automatic logic [7:0] rand_mask();
        case ($urandom_range(0, 4))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Offer one pixel and hold it until the transfer; keep valid high when
    // the next pixel follows without a gap.
    task automatic send_pixel(input logic [31:0] dest, input logic [31:0] src,
                              input logic [7:0] mask, input logic typed,
                              input logic [31:0] want);
        int unsigned gap;
        gap = pick_gap(src_calm);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tdata  <= {mask, src, dest};
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_pixels.push_back(typed ? want : blend_pixel(dest, src, mask));
        pixels_sent++;
    endtask

    // Drop valid, wait for every predicted pixel, then let the pipe empty.
    task automatic drain_pipe();
        s_axis_tvalid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (PIPE_LATENCY + 3) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] addr, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        @(posedge i_clk);
    endtask

    // Reprogram all four registers with the block idle.
    task automatic program_blend(input logic kind, input logic [23:0] color,
                                 input logic [7:0] opa, input logic men);
        drain_pipe();
        write_reg(CFG_SOURCE_KIND, CFG_DATA_W'(kind));
        write_reg(CFG_FILL_COLOR,  CFG_DATA_W'(color));
        write_reg(CFG_OPACITY,     CFG_DATA_W'(opa));
        write_reg(CFG_MASK_ENABLE, CFG_DATA_W'(men));
        i_cfg_we    <= 1'b0;
        cfg_kind    = kind;
        cfg_color   = color;
        cfg_opacity = opa;
        cfg_mask_en = men;
        settings_used++;
    endtask

    // Output side: check each transfer against the oldest prediction and
    // choose the next ready, including one long hold-off on request.
    initial begin : result_sink
        int unsigned stall_left;
        bit          hold_done;
        logic [31:0] want;
        stall_left = 0;
        hold_done  = 1'b0;
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_pixels.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("unexpected result pixel %08h", m_axis_tdata);
                end else begin
                    want = pending_pixels.pop_front();
                    pixels_checked++;
                    if (m_axis_tdata !== want) begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                            $display("result_pixel mismatch: expected %08h got %08h",
                                     want, m_axis_tdata);
                    end
                end
            end
            if (hold_request && !hold_done) begin
                hold_done  = 1'b1;
                stall_left = LONG_HOLD;
            end
            if (stall_left != 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= 1'b1;
                stall_left = pick_gap(sink_calm);
            end
        end
    end

    // Hard stop if the run hangs.
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin : stimulus
        t_row        row;
        logic        kind;
        logic        men;
        logic [7:0]  opa;
        logic [23:0] color;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table: switch registers only when the row asks for it.
        for (int i = 0; i < ROW_COUNT; i++) begin
            row = DIRECTED_ROWS[i];
            if (row.kind != cfg_kind || row.color != cfg_color ||
                row.opa != cfg_opacity || row.men != cfg_mask_en)
                program_blend(row.kind, row.color, row.opa, row.men);
            send_pixel(row.dest, row.src, row.mask, row.typed, row.want);
        end

        // Random phases walk all mode/mask combinations twice.
        for (int p = 0; p < PHASES; p++) begin
            kind = p[0];
            men  = p[1];
            case ($urandom_range(0, 4))
                0:       opa = 8'd0;
                1:       opa = 8'd255;
                2:       opa = 8'($urandom_range(1, 3));
                3:       opa = 8'($urandom_range(252, 254));
                default: opa = 8'($urandom_range(0, 255));
            endcase
            case ($urandom_range(0, 3))
                0:       color = 24'h000000;
                1:       color = 24'hFFFFFF;
                default: color = 24'($urandom);
            endcase
            program_blend(kind, color, opa, men);
            // Back up the output while this phase keeps feeding pixels.
            if (p == 3)
                hold_request = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_pixel(rand_argb(), rand_argb(), rand_mask(), 1'b0, 32'h0);
        end

        drain_pipe();
        repeat (3 * PIPE_LATENCY) @(posedge i_clk);

        $display("Sent %0d pixels under %0d register settings (fill and image, mask on/off)",
                 pixels_sent, settings_used);
        $display("Checked %0d results, with a %0d-cycle output hold backing up the input",
                 pixels_checked, LONG_HOLD);
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
